FILE: sv/s256_pkg.sv
// Package with the SHA-256 types, constants and round functions.
`timescale 1ns / 1ps
package s256_pkg;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_ROUND,
      RD_FINAL
   } round_state_type;

   typedef enum logic [1:0] {
      CSR_EXPECTED_0 = 2'd0,
      CSR_EXPECTED_1 = 2'd1,
      CSR_EXPECTED_2 = 2'd2,
      CSR_EXPECTED_3 = 2'd3
   } csr_index_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;

   typedef struct packed {
      logic [511:0] block;
      logic         last;
   } block_job_type;

   function automatic logic [255:0] init_hash();
      init_hash = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      round_k = k;
   endfunction

   function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
      ror32 = (v >> n) | (v << (32 - n));
   endfunction

endpackage

FILE: sv/sha256_stream_digest_check.sv
// Top level: SHA-256 byte-stream hasher with digest check.
// Bytes are taken one per cycle; a queued block holds the input until the round
// engine takes it, and the round time of each block there sets the sustained rate.
// First slice of a digest: follows the rounds of the final block, a second block when
// padding spills over, and waits for any earlier block that is still in rounds.
// Synchronous active-high reset restores initial hash values and clears counts.
`timescale 1ns / 1ps
module sha256_stream_digest_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_digest_slice,
   output logic [1:0]  rsp_slice_index,
   output logic        rsp_digest_matches,
   output logic        rsp_last_slice,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import s256_pkg::*;

   logic [63:0]   exp_ff [4];
   logic          job_valid, job_take;
   block_job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) exp_ff[i] <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_EXPECTED_0: exp_ff[0] <= csr_data;
            CSR_EXPECTED_1: exp_ff[1] <= csr_data;
            CSR_EXPECTED_2: exp_ff[2] <= csr_data;
            CSR_EXPECTED_3: exp_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   s256_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_data_byte(req_data_byte), .req_byte_present(req_byte_present),
      .req_end_of_message(req_end_of_message),
      .job_valid(job_valid), .job(job), .job_take(job_take)
   );

   s256_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job(job), .job_take(job_take),
      .expected({exp_ff[0], exp_ff[1], exp_ff[2], exp_ff[3]}),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_digest_slice(rsp_digest_slice), .rsp_slice_index(rsp_slice_index),
      .rsp_digest_matches(rsp_digest_matches), .rsp_last_slice(rsp_last_slice)
   );

endmodule

FILE: sv/s256_front.sv
// Byte collector: builds blocks, inserts padding and length, queues block jobs.
`timescale 1ns / 1ps
module s256_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_byte_present,
   input  logic                    req_end_of_message,
   output logic                    job_valid,
   output s256_pkg::block_job_type job,
   input  logic                    job_take
);
   import s256_pkg::*;

   logic [511:0] buf_ff, buf_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  len_ff, len_in;
   // pending padding: 0 none, 1 needs zero block with length
   logic         pad_ff, pad_in;
   block_job_type q_ff [2];
   logic [1:0]   qcnt_ff, qcnt_in;
   logic         qrd_ff, qwr_ff;

   logic         accept;
   logic         push1, push2;
   block_job_type j1, j2;
   logic [511:0] b;
   logic [5:0]   f;
   logic [63:0]  bits;

   assign accept   = req_push && !req_full;
   // an end item may push two blocks; require room for two and no pending pad
   assign req_full = (qcnt_ff != 2'd0) || pad_ff;

   always_comb begin
      b       = buf_ff;
      f       = fill_ff;
      len_in  = len_ff;
      push1   = 1'b0;
      push2   = 1'b0;
      j1      = '0;
      j2      = '0;
      pad_in  = pad_ff;
      bits    = '0;
      if (accept) begin
         if (req_byte_present) begin
            b[511 - 8*f -: 8] = req_data_byte;
            len_in = len_ff + 61'd1;
            f = f + 6'd1;
            if (f == 6'd0) begin
               push1 = 1'b1;
               j1.block = b;
               j1.last = 1'b0;
            end
         end
         if (req_end_of_message) begin
            bits = {len_in, 3'b000};
            if (f < LEN_OFFSET) begin
               for (int i = 0; i < 64; i++) begin
                  if (i[5:0] == f) b[511 - 8*i -: 8] = PAD_BYTE;
                  else if (i[5:0] > f && i < 56) b[511 - 8*i -: 8] = 8'h00;
               end
               b[63:0] = bits;
               if (push1) begin
                  j2.block = b; j2.last = 1'b1; push2 = 1'b1;
               end else begin
                  j1.block = b; j1.last = 1'b1; push1 = 1'b1;
               end
            end else begin
               for (int i = 0; i < 64; i++) begin
                  if (i[5:0] == f) b[511 - 8*i -: 8] = PAD_BYTE;
                  else if (i[5:0] > f) b[511 - 8*i -: 8] = 8'h00;
               end
               j1.block = b; j1.last = 1'b0; push1 = 1'b1;
               j2.block = {448'd0, bits}; j2.last = 1'b1; push2 = 1'b1;
            end
            f = 6'd0;
            len_in = '0;
         end
      end
      buf_in  = b;
      fill_in = f;
   end

   always_comb begin
      qcnt_in = qcnt_ff + {1'b0, push1} + {1'b0, push2} - {1'b0, job_take};
   end

   assign job_valid = (qcnt_ff != 2'd0);
   assign job       = q_ff[qrd_ff];

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (push1 && push2) begin
         q_ff[qwr_ff]  <= j1;
         q_ff[~qwr_ff] <= j2;
      end else if (push1) begin
         q_ff[qwr_ff] <= j1;
      end
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
         pad_ff  <= 1'b0;
         qcnt_ff <= '0;
         qrd_ff  <= 1'b0;
         qwr_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
         pad_ff  <= pad_in;
         qcnt_ff <= qcnt_in;
         if (job_take) qrd_ff <= ~qrd_ff;
         qwr_ff <= qwr_ff ^ push1 ^ push2;
      end
   end

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid) else $error("job taken from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= 2'd2) else $error("job queue overflow");
   a_fill_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_message |=> fill_ff == 6'd0)
      else $error("fill count not cleared after end");

endmodule

FILE: sv/s256_back.sv
// Compression engine: 64 rounds per block, digest slices into an output queue.
`timescale 1ns / 1ps
module s256_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  s256_pkg::block_job_type job,
   output logic                    job_take,
   input  logic [255:0]            expected,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [63:0]             rsp_digest_slice,
   output logic [1:0]              rsp_slice_index,
   output logic                    rsp_digest_matches,
   output logic                    rsp_last_slice
);
   import s256_pkg::*;

   round_state_type st_ff, st_in;
   logic [255:0] h_ff, h_in;
   logic [255:0] v_ff, v_in;
   logic [511:0] w_ff, w_in;
   logic [5:0]   rnd_ff;
   logic         last_ff;
   logic [255:0] dig_ff;
   logic         match_ff;
   logic [2:0]   out_cnt_ff;
   logic [1:0]   out_idx_ff;

   logic [31:0] a, bb, c, d, e, ff, g, hh, t1, t2, w0, s0, s1, wn, wi;
   logic        start, finish, out_busy;
   logic [255:0] sum;

   assign out_busy = (out_cnt_ff != 3'd0);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         RD_IDLE:  if (job_valid && !out_busy) st_in = RD_ROUND;
         RD_ROUND: if (rnd_ff == 6'd63) st_in = RD_FINAL;
         RD_FINAL: st_in = RD_IDLE;
         default:  st_in = RD_IDLE;
      endcase
   end

   always_comb begin
      start    = 1'b0;
      finish   = 1'b0;
      case (st_ff)
         RD_IDLE:  start  = job_valid && !out_busy;
         RD_FINAL: finish = 1'b1;
         default: ;
      endcase
   end
   assign job_take = start;

   always_comb begin
      {a, bb, c, d, e, ff, g, hh} = v_ff;
      wi = w_ff[511 -: 32];
      t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & ff) ^ (~e & g))
           + round_k(rnd_ff) + wi;
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & bb) ^ (a & c) ^ (bb & c));
      w0 = w_ff[511 -: 32];
      s0 = ror32(w_ff[479 -: 32], 7) ^ ror32(w_ff[479 -: 32], 18) ^ (w_ff[479 -: 32] >> 3);
      s1 = ror32(w_ff[63 -: 32], 17) ^ ror32(w_ff[63 -: 32], 19) ^ (w_ff[63 -: 32] >> 10);
      wn = w0 + s0 + w_ff[223 -: 32] + s1;
      for (int i = 0; i < 8; i++)
         sum[255 - 32*i -: 32] = h_ff[255 - 32*i -: 32] + v_ff[255 - 32*i -: 32];
      v_in = {t1 + t2, a, bb, c, d + t1, e, ff, g};
      w_in = {w_ff[479:0], wn};
      h_in = sum;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= h_ff;
         w_ff    <= job.block;
         last_ff <= job.last;
      end else if (st_ff == RD_ROUND) begin
         v_ff <= v_in;
         w_ff <= w_in;
      end
      if (finish && last_ff) begin
         dig_ff   <= sum;
         match_ff <= (sum == expected);
      end
      if (reset) begin
         st_ff      <= RD_IDLE;
         h_ff       <= init_hash();
         rnd_ff     <= '0;
         out_cnt_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         rnd_ff <= (st_ff == RD_ROUND) ? rnd_ff + 6'd1 : 6'd0;
         if (finish) h_ff <= last_ff ? init_hash() : h_in;
         if (finish && last_ff) begin
            out_cnt_ff <= 3'd4;
            out_idx_ff <= 2'd0;
         end else if (rsp_pop && out_busy) begin
            out_cnt_ff <= out_cnt_ff - 3'd1;
            out_idx_ff <= out_idx_ff + 2'd1;
         end
      end
   end

   assign rsp_empty          = !out_busy;
   assign rsp_digest_slice   = dig_ff[255 - 64*out_idx_ff -: 64];
   assign rsp_slice_index    = out_idx_ff;
   assign rsp_digest_matches = match_ff;
   assign rsp_last_slice     = (out_idx_ff == 2'd3);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |=> st_ff == RD_ROUND) else $error("round did not start");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_busy |-> st_ff == RD_IDLE || st_ff == RD_ROUND || st_ff == RD_FINAL)
      else $error("bad state");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !out_busy) else $error("block started while slices pending");

endmodule
